// ===== rtl/spi_binary_command_front_end_defines.svh =====
// Assertion macros for the SPI binary command front end.
// No dependencies; included by the top level, the only file that carries assertions.
`ifndef SPI_BINARY_COMMAND_FRONT_END_DEFINES_SVH
`define SPI_BINARY_COMMAND_FRONT_END_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define SBCFE_ASSERT_IMP(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("sbcfe assertion failed");

// Next-cycle implication, checked outside reset.
`define SBCFE_ASSERT_NXT(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("sbcfe assertion failed");

`else

`define SBCFE_ASSERT_IMP(label, clock, reset, cond, expr)
`define SBCFE_ASSERT_NXT(label, clock, reset, cond, expr)

`endif

`endif

// ===== rtl/sbcfe_pkg.sv =====
// Types, command codes and tables for the SPI binary command front end.
// No dependencies; used by sbcfe_decode, the top level and the testbench.
package sbcfe_pkg;

  // Longest bulk run after one bulk command.
  localparam int MAX_BULK = 16;
  localparam int BULK_W   = $clog2(MAX_BULK + 1);

  // High-nibble command codes; read commands also tag their reply with them.
  localparam logic [3:0] CMD_SYSTEM     = 4'h0;
  localparam logic [3:0] CMD_BULK       = 4'h1;
  localparam logic [3:0] CMD_NIB_LOW    = 4'h2;
  localparam logic [3:0] CMD_NIB_HIGH   = 4'h3;
  localparam logic [3:0] CMD_PERIPH_SET = 4'h4;
  localparam logic [3:0] CMD_PERIPH_GET = 4'h5;
  localparam logic [3:0] CMD_SPEED_SET  = 4'h6;
  localparam logic [3:0] CMD_SPEED_GET  = 4'h7;
  localparam logic [3:0] CMD_MODE_SET   = 4'h8;
  localparam logic [3:0] CMD_MODE_GET   = 4'h9;

  // Full-byte system commands.
  localparam logic [7:0] SYS_EXIT    = 8'h00;
  localparam logic [7:0] SYS_VERSION = 8'h01;
  localparam logic [7:0] SYS_CS_LOW  = 8'h02;
  localparam logic [7:0] SYS_CS_HIGH = 8'h03;

  localparam logic [7:0] REPLY_OK    = 8'h01;
  localparam logic [7:0] REPLY_ERROR = 8'h00;

  // Number of bytes in the version string.
  localparam int VERSION_LEN = 4;
  localparam int BEAT_W      = $clog2(VERSION_LEN);

  typedef struct packed {
    logic [7:0] host_byte;
    logic [7:0] miso_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_valid;
    logic       last;
    logic       spi_go;
    logic [7:0] mosi_byte;
    logic [3:0] pin_controls;
    logic [8:0] spi_setup;
    logic       leave_mode;
  } rsp_t;

  // Architectural state of the front end.
  typedef struct packed {
    logic [BULK_W-1:0] bulk_left;
    logic [7:0]        nibble_buffer;
    logic [3:0]        peripheral_readback;
    logic [3:0]        pin_levels;
    logic [2:0]        speed_index;
    logic [3:0]        spi_mode_bits;
    logic [3:0]        config_readback;
  } state_t;

  localparam state_t STATE_RESET = '{
    bulk_left:           '0,
    nibble_buffer:       8'h00,
    peripheral_readback: 4'h0,
    pin_levels:          4'b0001,
    speed_index:         3'd0,
    spi_mode_bits:       4'b1010,
    config_readback:     4'b0010
  };

  // What one decoded item leaves in the result stage.
  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_valid;
    logic       spi_go;
    logic [7:0] mosi_byte;
    logic       leave_mode;
    logic       version;
  } desc_t;

  // Prescaler code for each speed setting.
  function automatic logic [4:0] speed_code(input logic [2:0] idx);
    logic [4:0] code;
    case (idx)
      3'd0:    code = 5'b00000;
      3'd1:    code = 5'b11000;
      3'd2:    code = 5'b11100;
      3'd3:    code = 5'b11101;
      3'd4:    code = 5'b00011;
      3'd5:    code = 5'b01000;
      3'd6:    code = 5'b10000;
      default: code = 5'b11000;
    endcase
    return code;
  endfunction

  // Version string "SPI1", one character per beat.
  function automatic logic [7:0] version_char(input logic [BEAT_W-1:0] beat);
    logic [7:0] ch;
    case (beat)
      2'd0:    ch = 8'h53;
      2'd1:    ch = 8'h50;
      2'd2:    ch = 8'h49;
      default: ch = 8'h31;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/sbcfe_decode.sv =====
// Command decoder: next state and result descriptor for one host byte.
// Depends on sbcfe_pkg.
module sbcfe_decode (
  input  sbcfe_pkg::state_t cur,
  input  sbcfe_pkg::cmd_t   item,
  output sbcfe_pkg::state_t nxt,
  output sbcfe_pkg::desc_t  res
);
  import sbcfe_pkg::*;

  localparam logic [4:0] BULK_CAP = 5'(MAX_BULK);

  logic [3:0] lo;
  logic [4:0] run_len;
  logic [4:0] run_cap;
  logic [7:0] nib_new_low;

  assign lo          = item.host_byte[3:0];
  assign run_len     = {1'b0, lo} + 5'd1;
  assign run_cap     = (run_len > BULK_CAP) ? BULK_CAP : run_len;
  assign nib_new_low = {cur.nibble_buffer[7:4], lo};

  // Bulk data bypasses the command decoder; otherwise decode the high nibble.
  always_comb begin
    nxt             = cur;
    res             = '0;
    res.reply_valid = 1'b1;
    res.reply_byte  = REPLY_OK;
    if (cur.bulk_left != '0) begin
      nxt.bulk_left  = cur.bulk_left - BULK_W'(1);
      res.reply_byte = item.miso_byte;
      res.spi_go     = 1'b1;
      res.mosi_byte  = item.host_byte;
    end else begin
      unique case (item.host_byte[7:4])
        CMD_SYSTEM: begin
          unique case (item.host_byte)
            SYS_EXIT: begin
              nxt             = STATE_RESET;
              res.reply_byte  = REPLY_ERROR;
              res.reply_valid = 1'b0;
              res.leave_mode  = 1'b1;
            end
            SYS_VERSION: begin
              res.version = 1'b1;
            end
            SYS_CS_LOW: begin
              nxt.pin_levels[0]          = 1'b0;
              nxt.peripheral_readback[0] = 1'b0;
            end
            SYS_CS_HIGH: begin
              nxt.pin_levels[0]          = 1'b1;
              nxt.peripheral_readback[0] = 1'b1;
            end
            default: begin
              res.reply_byte = REPLY_ERROR;
            end
          endcase
        end
        CMD_BULK: begin
          nxt.bulk_left = run_cap[BULK_W-1:0];
        end
        CMD_NIB_LOW: begin
          nxt.nibble_buffer = nib_new_low;
          res.reply_byte    = item.miso_byte;
          res.spi_go        = 1'b1;
          res.mosi_byte     = nib_new_low;
        end
        CMD_NIB_HIGH: begin
          nxt.nibble_buffer = {lo, cur.nibble_buffer[3:0]};
        end
        CMD_PERIPH_SET: begin
          nxt.pin_levels          = lo;
          nxt.peripheral_readback = lo;
        end
        CMD_PERIPH_GET: begin
          res.reply_byte = {CMD_PERIPH_GET, cur.peripheral_readback};
        end
        CMD_SPEED_SET: begin
          nxt.speed_index = item.host_byte[2:0];
        end
        CMD_SPEED_GET: begin
          res.reply_byte = {CMD_SPEED_GET, 1'b0, cur.speed_index};
        end
        CMD_MODE_SET: begin
          nxt.spi_mode_bits   = lo;
          nxt.config_readback = lo;
        end
        CMD_MODE_GET: begin
          res.reply_byte = {CMD_MODE_GET, cur.config_readback};
        end
        default: begin
          res.reply_byte = REPLY_ERROR;
        end
      endcase
    end
  end

endmodule

// ===== rtl/spi_binary_command_front_end.sv =====
// SPI binary command front end: a command item is registered on transfer, then decoded
// into the result register. Throughput is one item per cycle while the receiver does not
// stall; the version command holds the result register for one result per string byte,
// and bulk or single commands give one result each.
// Synchronous active-high reset returns all state to startup values and empties both
// registers; no clearing pass is needed.
module spi_binary_command_front_end (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  sbcfe_pkg::cmd_t cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output sbcfe_pkg::rsp_t rsp
);
  import sbcfe_pkg::*;

  `include "spi_binary_command_front_end_defines.svh"

  // Input register.
  logic   in_full;
  cmd_t   in_item;

  // Result register and its beat counter for the version string.
  logic              out_full;
  desc_t             desc;
  logic [BEAT_W-1:0] banner_index;

  state_t state;
  state_t state_next;
  desc_t  desc_next;

  logic last_beat;
  logic out_take;
  logic out_done;
  logic advance;
  logic in_take;

  sbcfe_decode u_decode (
    .cur  (state),
    .item (in_item),
    .nxt  (state_next),
    .res  (desc_next)
  );

  // Handshake control: an item moves on once the result register frees up.
  assign last_beat = !desc.version || (banner_index == BEAT_W'(VERSION_LEN - 1));
  assign out_take  = out_full && !rsp_stall;
  assign out_done  = out_take && last_beat;
  assign advance   = in_full && (!out_full || out_done);
  assign cmd_stall = in_full && !advance;
  assign in_take   = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item <= cmd;
    end
  end

  // State and result register update on each decoded item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full     <= 1'b0;
      banner_index <= '0;
      state        <= STATE_RESET;
    end else if (advance) begin
      out_full     <= 1'b1;
      banner_index <= '0;
      state        <= state_next;
    end else if (out_done) begin
      out_full <= 1'b0;
    end else if (out_take) begin
      banner_index <= banner_index + BEAT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      desc <= desc_next;
    end
  end

  // Result fields; pin and setup values come from the state after the item.
  assign rsp_valid = out_full;
  always_comb begin
    rsp.reply_byte   = desc.version ? version_char(banner_index) : desc.reply_byte;
    rsp.reply_valid  = desc.reply_valid;
    rsp.last         = last_beat;
    rsp.spi_go       = desc.spi_go;
    rsp.mosi_byte    = desc.mosi_byte;
    rsp.pin_controls = state.pin_levels;
    rsp.spi_setup    = {state.spi_mode_bits, speed_code(state.speed_index)};
    rsp.leave_mode   = desc.leave_mode;
  end

  // A bulk run never exceeds its limit.
  `SBCFE_ASSERT_IMP(a_bulk_range, clk, rst, 1'b1, state.bulk_left <= BULK_W'(MAX_BULK))
  // Only the version command spreads over several results.
  `SBCFE_ASSERT_IMP(a_multi_version, clk, rst, rsp_valid && !rsp.last, desc.version)
  // An exchange always returns a byte to the host.
  `SBCFE_ASSERT_IMP(a_go_replies, clk, rst, rsp_valid && rsp.spi_go, rsp.reply_valid)
  // The exit result shows startup pins and command mode.
  `SBCFE_ASSERT_IMP(a_exit_reset, clk, rst, rsp_valid && rsp.leave_mode,
                    state.pin_levels == STATE_RESET.pin_levels && state.bulk_left == '0)
  // A non-final beat that is taken steps the version string.
  `SBCFE_ASSERT_NXT(a_beat_step, clk, rst, out_take && !last_beat,
                    out_full && banner_index == $past(banner_index) + BEAT_W'(1))

endmodule

// ===== bench/spi_binary_command_front_end_tb.sv =====
// Self-checking testbench for the SPI binary command front end.
// Depends on sbcfe_pkg for the transfer structs and command codes, and on the RTL top level.
module spi_binary_command_front_end_tb;
  import sbcfe_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEM_TARGET  = 430;
  localparam logic [31:0] VERSION_TEXT = "SPI1";

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Idling controls for the sender and the receiver, set by the test tasks.
  bit sender_idle   = 1'b1;
  bit receiver_idle = 1'b1;
  bit hold_request  = 1'b0;

  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Expected results, oldest first.
  rsp_t expected_rsp_q[$];
  rsp_t want_rsp;

  // Predicted front end state.
  logic [4:0] bulk_left_p;
  logic [7:0] nibble_p;
  logic [3:0] periph_rb_p;
  logic [3:0] pins_p;
  logic [2:0] speed_p;
  logic [3:0] mode_p;
  logic [3:0] cfg_rb_p;

  spi_binary_command_front_end i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Gap lengths: mostly none, some short, a few long.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Prescaler code selected by the speed setting.
  function automatic logic [4:0] prescale_code(input logic [2:0] idx);
    case (idx)
      3'd0:    return 5'b00000;
      3'd1:    return 5'b11000;
      3'd2:    return 5'b11100;
      3'd3:    return 5'b11101;
      3'd4:    return 5'b00011;
      3'd5:    return 5'b01000;
      3'd6:    return 5'b10000;
      default: return 5'b11000;
    endcase
  endfunction

  task automatic reset_front_end_state();
    bulk_left_p = '0;
    nibble_p    = 8'h00;
    periph_rb_p = 4'h0;
    pins_p      = 4'b0001;
    speed_p     = 3'd0;
    mode_p      = 4'b1010;
    cfg_rb_p    = 4'b0010;
  endtask

  // One result as seen with the current pin and setup state.
  function automatic rsp_t front_end_result(input logic [7:0] reply, input logic valid,
                                            input logic last_flag, input logic go,
                                            input logic [7:0] mosi, input logic leave);
    rsp_t r;
    r.reply_byte   = reply;
    r.reply_valid  = valid;
    r.last         = last_flag;
    r.spi_go       = go;
    r.mosi_byte    = mosi;
    r.pin_controls = pins_p;
    r.spi_setup    = {mode_p, prescale_code(speed_p)};
    r.leave_mode   = leave;
    return r;
  endfunction

  // Update the predicted state for one command transfer and queue its results.
  task automatic predict_front_end(input logic [7:0] host, input logic [7:0] miso);
    logic [3:0] lo;
    int k;
    lo = host[3:0];
    if (bulk_left_p != 0) begin
      bulk_left_p = bulk_left_p - 1'b1;
      expected_rsp_q.push_back(front_end_result(miso, 1'b1, 1'b1, 1'b1, host, 1'b0));
      return;
    end
    case (host[7:4])
      CMD_SYSTEM: begin
        if (host == SYS_EXIT) begin
          reset_front_end_state();
          expected_rsp_q.push_back(front_end_result(8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1));
        end else if (host == SYS_VERSION) begin
          for (k = 0; k < VERSION_LEN; k++) begin
            expected_rsp_q.push_back(front_end_result(VERSION_TEXT[31 - 8 * k -: 8], 1'b1,
                                                      k == VERSION_LEN - 1, 1'b0, 8'h00,
                                                      1'b0));
          end
        end else if (host == SYS_CS_LOW || host == SYS_CS_HIGH) begin
          pins_p[0]      = (host == SYS_CS_HIGH);
          periph_rb_p[0] = (host == SYS_CS_HIGH);
          expected_rsp_q.push_back(front_end_result(REPLY_OK, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
        end else begin
          expected_rsp_q.push_back(front_end_result(REPLY_ERROR, 1'b1, 1'b1, 1'b0, 8'h00,
                                                    1'b0));
        end
      end
      CMD_BULK: begin
        // The low nibble tops out at 15, so the run never exceeds the bulk limit.
        bulk_left_p = 5'(lo) + 5'd1;
        if (bulk_left_p > MAX_BULK) bulk_left_p = 5'(MAX_BULK);
        expected_rsp_q.push_back(front_end_result(REPLY_OK, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
      end
      CMD_NIB_LOW: begin
        nibble_p[3:0] = lo;
        expected_rsp_q.push_back(front_end_result(miso, 1'b1, 1'b1, 1'b1, nibble_p, 1'b0));
      end
      CMD_NIB_HIGH: begin
        nibble_p[7:4] = lo;
        expected_rsp_q.push_back(front_end_result(REPLY_OK, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
      end
      CMD_PERIPH_SET: begin
        pins_p      = lo;
        periph_rb_p = lo;
        expected_rsp_q.push_back(front_end_result(REPLY_OK, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
      end
      CMD_PERIPH_GET: begin
        expected_rsp_q.push_back(front_end_result({CMD_PERIPH_GET, periph_rb_p}, 1'b1, 1'b1,
                                                  1'b0, 8'h00, 1'b0));
      end
      CMD_SPEED_SET: begin
        // Bit 3 of the argument is ignored.
        speed_p = host[2:0];
        expected_rsp_q.push_back(front_end_result(REPLY_OK, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
      end
      CMD_SPEED_GET: begin
        expected_rsp_q.push_back(front_end_result({CMD_SPEED_GET, 1'b0, speed_p}, 1'b1, 1'b1,
                                                  1'b0, 8'h00, 1'b0));
      end
      CMD_MODE_SET: begin
        mode_p   = lo;
        cfg_rb_p = lo;
        expected_rsp_q.push_back(front_end_result(REPLY_OK, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
      end
      CMD_MODE_GET: begin
        expected_rsp_q.push_back(front_end_result({CMD_MODE_GET, cfg_rb_p}, 1'b1, 1'b1,
                                                  1'b0, 8'h00, 1'b0));
      end
      default: begin
        expected_rsp_q.push_back(front_end_result(REPLY_ERROR, 1'b1, 1'b1, 1'b0, 8'h00,
                                                  1'b0));
      end
    endcase
  endtask

  // Offer one command item and wait for its transfer. Valid stays high into the next
  // item when no gap is chosen.
  task automatic send_cmd(input logic [7:0] host, input logic [7:0] miso);
    int gap;
    gap = sender_idle ? pick_gap() : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= '{host_byte: host, miso_byte: miso};
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_front_end(host, miso);
    items_sent++;
  endtask

  // One command from a mostly well-formed stream: bulk runs carry random data, with some
  // unknown codes, exits and fully random bytes mixed in.
  task automatic send_random_command();
    int unsigned pick;
    logic [3:0] lo;
    int n;
    pick = $urandom_range(0, 99);
    lo   = 4'($urandom_range(0, 15));
    if (pick < 22) begin
      send_cmd({CMD_BULK, lo}, rand_byte());
      for (n = 0; n <= int'(lo); n++) send_cmd(rand_byte(), rand_byte());
    end else if (pick < 30) begin
      send_cmd(SYS_VERSION, rand_byte());
    end else if (pick < 35) begin
      send_cmd($urandom_range(0, 1) ? SYS_CS_HIGH : SYS_CS_LOW, rand_byte());
    end else if (pick < 85) begin
      send_cmd({4'($urandom_range(CMD_NIB_LOW, CMD_MODE_GET)), lo}, rand_byte());
    end else if (pick < 91) begin
      send_cmd({CMD_SYSTEM, 4'($urandom_range(4, 15))}, rand_byte());
    end else if (pick < 96) begin
      send_cmd({4'($urandom_range(10, 15)), lo}, rand_byte());
    end else if (pick < 98) begin
      send_cmd(SYS_EXIT, rand_byte());
    end else begin
      send_cmd(rand_byte(), rand_byte());
    end
  endtask

  // Compare one field of a result.
  task automatic check_field(input string field, input logic [8:0] want,
                             input logic [8:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch on %s: expected %h, actual %h", field, want, got);
      end
    end
  endtask

  // Result checker: each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result with nothing expected: %h", rsp);
      end else begin
        want_rsp = expected_rsp_q.pop_front();
        check_field("reply_byte", 9'(want_rsp.reply_byte), 9'(rsp.reply_byte));
        check_field("reply_valid", 9'(want_rsp.reply_valid), 9'(rsp.reply_valid));
        check_field("last", 9'(want_rsp.last), 9'(rsp.last));
        check_field("spi_go", 9'(want_rsp.spi_go), 9'(rsp.spi_go));
        check_field("mosi_byte", 9'(want_rsp.mosi_byte), 9'(rsp.mosi_byte));
        check_field("pin_controls", 9'(want_rsp.pin_controls), 9'(rsp.pin_controls));
        check_field("spi_setup", want_rsp.spi_setup, rsp.spi_setup);
        check_field("leave_mode", 9'(want_rsp.leave_mode), 9'(rsp.leave_mode));
      end
    end
  end

  // Receiver stalls: random runs, or one long hold-off when a test asks for it.
  initial begin : receiver_stall
    int stall_left;
    int hold_count;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        rsp_stall <= 1'b1;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
        hold_request = 1'b0;
        rsp_stall   <= 1'b0;
      end else begin
        if (stall_left == 0 && receiver_idle && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
        if (stall_left > 0) begin
          stall_left--;
          rsp_stall <= 1'b1;
        end else begin
          rsp_stall <= 1'b0;
        end
      end
    end
  end

  // Every command at least once, mode and peripheral readbacks at reset, ignored bits,
  // unknown codes, the shortest bulk run with a data byte that looks like exit, and exit.
  task automatic test_directed_commands();
    send_cmd({CMD_MODE_GET, 4'h0}, 8'h00);
    send_cmd({CMD_PERIPH_GET, 4'h0}, 8'h00);
    send_cmd(SYS_VERSION, 8'hFF);
    send_cmd(SYS_CS_LOW, 8'h00);
    send_cmd({CMD_PERIPH_GET, 4'hF}, 8'h00);
    send_cmd(SYS_CS_HIGH, 8'h00);
    send_cmd({CMD_PERIPH_SET, 4'hF}, 8'h00);
    send_cmd({CMD_PERIPH_SET, 4'h0}, 8'h00);
    send_cmd({CMD_SPEED_SET, 4'hF}, 8'h00);
    send_cmd({CMD_SPEED_GET, 4'hA}, 8'h00);
    send_cmd({CMD_SPEED_SET, 4'h0}, 8'h00);
    send_cmd({CMD_MODE_SET, 4'hF}, 8'h00);
    send_cmd({CMD_MODE_GET, 4'hC}, 8'h00);
    send_cmd({CMD_MODE_SET, 4'h0}, 8'h00);
    send_cmd({CMD_NIB_HIGH, 4'hF}, 8'h00);
    send_cmd({CMD_NIB_LOW, 4'h0}, 8'hFF);
    send_cmd({CMD_NIB_LOW, 4'hF}, 8'h00);
    send_cmd({CMD_SYSTEM, 4'h4}, 8'h00);
    send_cmd({CMD_SYSTEM, 4'hF}, 8'h00);
    send_cmd({4'hA, 4'h5}, 8'h00);
    send_cmd({4'hF, 4'hF}, 8'hFF);
    send_cmd({CMD_BULK, 4'h0}, 8'h00);
    send_cmd(SYS_EXIT, 8'hFF);
    send_cmd(SYS_EXIT, 8'h00);
    send_cmd({CMD_MODE_GET, 4'h0}, 8'h00);
  endtask

  // The longest bulk run and a stream of commands with no idling on either side.
  task automatic test_back_to_back_bulk();
    int n;
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    send_cmd({CMD_BULK, 4'hF}, rand_byte());
    for (n = 0; n < MAX_BULK; n++) send_cmd(rand_byte(), rand_byte());
    for (n = 0; n < 10; n++) send_random_command();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the block
  // fills up and stalls its input.
  task automatic test_output_hold_off();
    int unsigned stop_at;
    sender_idle  = 1'b0;
    hold_request = 1'b1;
    stop_at      = items_sent + 30;
    send_cmd(SYS_VERSION, rand_byte());
    send_cmd(SYS_VERSION, rand_byte());
    while (items_sent < stop_at) send_random_command();
    sender_idle = 1'b1;
  endtask

  // Random command streams with random idling on both sides.
  task automatic test_random_commands();
    while (items_sent < ITEM_TARGET) send_random_command();
  endtask

  // Wait for the last results, then report.
  task automatic finish_run();
    cmd_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  endtask

  initial begin
    reset_front_end_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_back_to_back_bulk();
    test_output_hold_off();
    test_random_commands();
    finish_run();
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sbcfe_pkg.sv
rtl/sbcfe_decode.sv
rtl/spi_binary_command_front_end.sv
bench/spi_binary_command_front_end_tb.sv
